### src/vef_pkg.sv
// ----------------------------------------------------------------------------
// vef_pkg: shared types and constants of the VT100 escape filter
// Character codes, request structs for both channels, and the records that
// pass between the classifier, the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package vef_pkg;

	// Number of bytes from the window head that the classifier inspects.
	localparam int SCAN_LEN = 14;
	localparam int SKIP_W = 4;
	localparam int CNT_W = 4;
	// Most results that one buffer's final request may produce.
	localparam int RES_MAX = 15;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [7:0] byte_t;
	typedef logic [SCAN_LEN-1:0][7:0] scan_t;
	typedef logic [SKIP_W-1:0] skip_t;

	localparam byte_t CH_ESC = 8'h1B;
	localparam byte_t CH_CSI = 8'h5B;
	localparam byte_t CH_M = 8'h6D;
	localparam byte_t CH_K = 8'h4B;
	localparam byte_t CH_O = 8'h6F;
	localparam byte_t CH_L = 8'h6C;
	localparam byte_t CH_0 = 8'h30;
	localparam byte_t CH_1 = 8'h31;
	localparam byte_t CH_2 = 8'h32;
	localparam byte_t CH_3 = 8'h33;
	localparam byte_t CH_4 = 8'h34;
	localparam byte_t CH_5 = 8'h35;
	localparam byte_t CH_8 = 8'h38;
	localparam byte_t CH_SEMI = 8'h3B;

	typedef struct packed {
		byte_t in_byte;
		logic in_last;
	} in_item_t;

	typedef struct packed {
		byte_t out_byte;
		logic out_has_byte;
		logic out_last;
	} out_item_t;

	// One queued action: one or two output bytes, or the empty end marker.
	typedef struct packed {
		logic two;
		byte_t byte0;
		byte_t byte1;
		logic has_byte;
		logic last;
	} action_t;

	// Decision for the byte at the window head.
	typedef struct packed {
		logic [1:0] nres;
		byte_t byte0;
		byte_t byte1;
		skip_t skip_next;
	} cls_t;

endpackage

### src/vef_classify.sv
// ----------------------------------------------------------------------------
// vef_classify: head-of-window decision
// Looks at the first bytes of the lookahead window and decides whether the
// head byte is copied, dropped, or starts a CSI sequence to strip or rewrite.
// ----------------------------------------------------------------------------
module vef_classify
	import vef_pkg::*;
(
	input  scan_t scan,
	input  skip_t skip,
	output cls_t  cls
);

	logic  is_color;
	skip_t mv;
	skip_t mv_color;
	skip_t mv_plain;

	always_comb begin
		is_color = (scan[2] == CH_3 || scan[2] == CH_4) && scan[3] == CH_8 &&
			scan[4] == CH_SEMI && scan[5] == CH_5 && scan[6] == CH_SEMI;

		// First 'm' wins: scan downward so the lowest match is kept.
		mv_color = skip_t'(2);
		for (int k = 13; k >= 7; k--) begin
			if (scan[k] == CH_M) begin
				mv_color = skip_t'(k + 1);
			end
		end
		mv_plain = skip_t'(2);
		for (int k = 9; k >= 2; k--) begin
			if (scan[k] == CH_M) begin
				mv_plain = skip_t'(k + 1);
			end
		end

		cls = '0;
		mv = skip_t'(1);
		if (skip != '0) begin
			cls.skip_next = skip - 1'b1;
		end else if (scan[0] == CH_ESC && scan[1] == CH_CSI) begin
			if (scan[3] == CH_M) begin
				mv = skip_t'(4);
			end else if (scan[4] == CH_M) begin
				mv = skip_t'(5);
			end else if (scan[5] == CH_M) begin
				mv = skip_t'(6);
			end else if (scan[2] == CH_K) begin
				cls.nres = 2'd2;
				cls.byte0 = CH_ESC;
				cls.byte1 = CH_K;
				mv = skip_t'(3);
			end else if (scan[3] == CH_K) begin
				cls.nres = 2'd1;
				cls.byte0 = CH_ESC;
				case (scan[2])
					CH_0: begin
						cls.nres = 2'd2;
						cls.byte1 = CH_K;
					end
					CH_1: begin
						cls.nres = 2'd2;
						cls.byte1 = CH_O;
					end
					CH_2: begin
						cls.nres = 2'd2;
						cls.byte1 = CH_L;
					end
					default: begin
						cls.nres = 2'd1;
					end
				endcase
				mv = skip_t'(4);
			end else if (is_color) begin
				mv = mv_color;
			end else begin
				mv = mv_plain;
			end
			cls.skip_next = mv - 1'b1;
		end else begin
			cls.nres = 2'd1;
			cls.byte0 = scan[0];
		end
	end

endmodule

### src/vef_front.sv
// ----------------------------------------------------------------------------
// vef_front: input side of the filter
// Holds the lookahead window, decides on the head byte as the window fills,
// drains the window at the end of a buffer and queues the resulting actions.
// ----------------------------------------------------------------------------
module vef_front
	import vef_pkg::*;
#(
	parameter int LOOKAHEAD = 14
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  in_item_t src_data,
	output logic     push,
	output action_t  push_data,
	input  logic     q_full
);

	localparam int FILL_W = $clog2(LOOKAHEAD + 1);
	localparam logic [FILL_W-1:0] FULL_M1 = FILL_W'(LOOKAHEAD - 1);
	localparam logic [CNT_W-1:0] RES_CAP = CNT_W'(RES_MAX);

	typedef enum logic [1:0] {
		FS_RUN,
		FS_DRAIN,
		FS_CLOSE
	} fstate_t;

	fstate_t state_q;
	logic [LOOKAHEAD-1:0][7:0] win_q;
	logic [LOOKAHEAD-1:0][7:0] ext;
	logic [FILL_W-1:0] fill_q;
	skip_t skip_q;
	logic [CNT_W-1:0] cnt_q;
	logic pend_valid_q;
	action_t pend_q;

	scan_t scan;
	cls_t cls;
	logic accept;
	logic proc_run;
	logic proc_drain;
	logic close;
	logic [CNT_W-1:0] room;
	logic [1:0] nkeep;
	action_t new_act;
	action_t marker;

	// The incoming byte lands at the fill position; beyond the fill the
	// window always holds zero, which is what lookahead past the end reads.
	always_comb begin
		for (int k = 0; k < LOOKAHEAD; k++) begin
			ext[k] = (state_q == FS_RUN && FILL_W'(k) == fill_q) ? src_data.in_byte : win_q[k];
		end
	end

	assign scan = ext[SCAN_LEN-1:0];

	vef_classify u_classify (
		.scan (scan),
		.skip (skip_q),
		.cls  (cls)
	);

	assign src_stall = (state_q != FS_RUN) || q_full;
	assign accept = src_valid && !src_stall;
	assign proc_run = accept && !src_data.in_last && fill_q == FULL_M1;
	assign proc_drain = state_q == FS_DRAIN && !q_full;
	assign close = state_q == FS_CLOSE && !q_full;

	assign room = RES_CAP - cnt_q;

	always_comb begin
		nkeep = cls.nres;
		if (state_q == FS_DRAIN && CNT_W'(cls.nres) > room) begin
			nkeep = room[1:0];
		end
		new_act.two = nkeep == 2'd2;
		new_act.byte0 = cls.byte0;
		new_act.byte1 = cls.byte1;
		new_act.has_byte = 1'b1;
		new_act.last = 1'b0;

		marker = '0;
		marker.last = 1'b1;

		push = 1'b0;
		push_data = new_act;
		if (proc_run) begin
			push = nkeep != 2'd0;
		end else if (proc_drain) begin
			push = nkeep != 2'd0 && pend_valid_q;
			push_data = pend_q;
		end else if (close) begin
			push = 1'b1;
			if (pend_valid_q) begin
				push_data = pend_q;
				push_data.last = 1'b1;
			end else begin
				push_data = marker;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_RUN;
			win_q <= '0;
			fill_q <= '0;
			skip_q <= '0;
			cnt_q <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				FS_RUN: begin
					if (proc_run) begin
						for (int k = 0; k < LOOKAHEAD - 1; k++) begin
							win_q[k] <= ext[k + 1];
						end
						win_q[LOOKAHEAD-1] <= '0;
						skip_q <= cls.skip_next;
					end else if (accept) begin
						win_q <= ext;
						fill_q <= fill_q + 1'b1;
						if (src_data.in_last) begin
							state_q <= FS_DRAIN;
							cnt_q <= '0;
						end
					end
				end
				FS_DRAIN: begin
					if (proc_drain) begin
						for (int k = 0; k < LOOKAHEAD - 1; k++) begin
							win_q[k] <= win_q[k + 1];
						end
						win_q[LOOKAHEAD-1] <= '0;
						fill_q <= fill_q - 1'b1;
						skip_q <= cls.skip_next;
						cnt_q <= cnt_q + CNT_W'(nkeep);
						if (nkeep != 2'd0) begin
							pend_valid_q <= 1'b1;
							pend_q <= new_act;
						end
						if (fill_q == FILL_W'(1)) begin
							state_q <= FS_CLOSE;
						end
					end
				end
				FS_CLOSE: begin
					if (close) begin
						pend_valid_q <= 1'b0;
						skip_q <= '0;
						state_q <= FS_RUN;
					end
				end
				default: begin
					state_q <= FS_RUN;
				end
			endcase
		end
	end

endmodule

### src/vef_queue.sv
// ----------------------------------------------------------------------------
// vef_queue: action queue between front and back end
// A small first-in first-out buffer of actions, one write and one read a cycle.
// ----------------------------------------------------------------------------
module vef_queue
	import vef_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  action_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output action_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	action_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full = count_q == CNT_QW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/vef_back.sv
// ----------------------------------------------------------------------------
// vef_back: output side of the filter
// Takes actions from the queue and presents their bytes one request at a time.
// ----------------------------------------------------------------------------
module vef_back
	import vef_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  action_t   q_head,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data
);

	logic cur_valid_q;
	logic second_q;
	action_t cur_q;
	logic at_final;
	logic taken;

	assign at_final = !cur_q.two || second_q;
	assign taken = cur_valid_q && !dst_stall;
	assign pop = !q_empty && (!cur_valid_q || (taken && at_final));

	assign dst_valid = cur_valid_q;
	assign dst_data.out_byte = second_q ? cur_q.byte1 : cur_q.byte0;
	assign dst_data.out_has_byte = cur_q.has_byte;
	assign dst_data.out_last = cur_q.last && at_final;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				second_q <= 1'b0;
			end else if (taken && at_final) begin
				cur_valid_q <= 1'b0;
				second_q <= 1'b0;
			end else if (taken) begin
				second_q <= 1'b1;
			end
		end
	end

endmodule

### src/vt100_escape_filter.sv
// ----------------------------------------------------------------------------
// vt100_escape_filter: streaming VT100 CSI sequence stripper
// Removes or rewrites ESC '[' sequences in a terminal byte stream, deciding on
// each byte with a lookahead window of the following bytes.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload    | Request taken when
//   --------+-----------+------------+-----------------------------
//   src     | in        | in_item_t  | src_valid high, src_stall low
//   dst     | out       | out_item_t | dst_valid high, dst_stall low
//
// One byte is taken every cycle while a buffer streams in and the queue has
// room; the head decision is made in the same cycle from the window registers
// and the arriving byte. After a request marked last, src_stall is high while
// the window drains one byte per cycle, queue permitting, and then closes.
// A four-entry action queue separates the front end from the output stage, so
// dst_stall only pushes back on src once the queue is full.
// Reset clears the window, counters, queue pointers and output valid.
// ----------------------------------------------------------------------------
module vt100_escape_filter
	import vef_pkg::*;
#(
	parameter int LOOKAHEAD = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_data,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data
);

	// Actions flow from the front end into the queue.
	logic    push;
	action_t push_data;
	logic    q_full;

	// The output stage pulls actions out of the queue.
	logic    pop;
	logic    q_empty;
	action_t q_head;

	// Front end: window, head classification and end-of-buffer drain.
	vef_front #(
		.LOOKAHEAD (LOOKAHEAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Decoupling queue between the two halves.
	vef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Back end: expands each action into one or two output requests.
	vef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule
